// ----- rtl/core/sdm_pkg.sv -----
// Package for the surround downmix mixer: widths, coefficients, reorder tables,
// configuration codes and the shared fixed-point helpers.
// No dependencies.
package sdm_pkg;

    localparam int NumCh   = 6;
    localparam int SampleW = 16;
    localparam int CountW  = 3;
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 48;
    localparam int DataW   = 104;  // count + six samples, padded to whole bytes
    localparam int ProdW   = 17;   // floor(v * k / 2^16) for 16-bit v, k
    localparam int SumW    = 20;

    localparam logic [SampleW-1:0] CoefFront   = 16'd26869;
    localparam logic [SampleW-1:0] CoefCenter  = 16'd19196;
    localparam logic [SampleW-1:0] CoefLfe     = 16'd13571;
    localparam logic [SampleW-1:0] CoefPhantom = 16'd46334;

    localparam logic signed [SumW-1:0] ClipHi = 20'sd32767;
    localparam logic signed [SumW-1:0] ClipLo = -20'sd32768;

    localparam logic [CountW-1:0] AacTab [NumCh] = '{3'd1, 3'd2, 3'd4, 3'd5, 3'd0, 3'd3};
    localparam logic [CountW-1:0] Ac3Tab [NumCh] = '{3'd0, 3'd2, 3'd3, 3'd4, 3'd1, 3'd5};

    typedef logic signed [SampleW-1:0] sample_t;
    typedef logic signed [ProdW-1:0]   prod_t;

    typedef enum logic [1:0] {
        SWZ_NONE = 2'd0,
        SWZ_AAC  = 2'd1,
        SWZ_AC3  = 2'd2,
        SWZ_RSVD = 2'd3
    } swz_mode_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SWIZZLE   = 3'd0,
        CFG_STEREO    = 3'd1,
        CFG_PH_LFE    = 3'd2,
        CFG_PH_CENTER = 3'd3,
        CFG_GAIN_EN   = 3'd4,
        CFG_GAINS_LO  = 3'd5,
        CFG_GAINS_HI  = 3'd6,
        CFG_UNUSED    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic                           stereo_only;
        logic                           phantom_lfe;
        logic                           phantom_center;
        logic                           gain_enable;
        logic [NumCh-1:0][SampleW-1:0]  gains;
    } mix_cfg_t;

    // floor(v * k / 65536), k unsigned
    function automatic prod_t fmul(input sample_t v, input logic [SampleW-1:0] k);
        logic signed [2*SampleW:0] p;
        p = v * $signed({1'b0, k});
        return p[2*SampleW:SampleW];
    endfunction

    function automatic sample_t clip16(input logic signed [SumW-1:0] v);
        sample_t r;
        if (v > ClipHi)
            r = sample_t'(ClipHi);
        else if (v < ClipLo)
            r = sample_t'(ClipLo);
        else
            r = v[SampleW-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/core/surround_downmix_mixer.sv -----
// Surround downmix mixer top level: stream ports, configuration registers,
// count clamp and channel reorder stage; mixing runs in sdm_mix.
// Depends on sdm_pkg and sdm_mix.
// Throughput: one beat per cycle while the output stage is empty or taken.
// The six pipeline stages advance together whenever the output stage is empty or taken.
// Reset clears all valid bits and the configuration registers to zero.
module surround_downmix_mixer
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // channel_count[2:0], in_sample_0..in_sample_5 at [18:3] .. [98:83], zero pad
    input  logic [sdm_pkg::DataW-1:0]    s_axis_tdata,
    input  logic                         s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // out_channel_count[2:0], out_sample_0..out_sample_5 at [18:3] .. [98:83], zero pad
    output logic [sdm_pkg::DataW-1:0]    m_axis_tdata,
    output logic                         m_axis_tlast,
    input  logic                         cfg_we,
    input  logic [sdm_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [sdm_pkg::CfgW-1:0]     cfg_data
);

    logic [1:0]                 swz_reg;
    sdm_pkg::mix_cfg_t          cfg_reg;

    logic                       en;
    logic                       v1_reg;
    logic [sdm_pkg::CountW-1:0] ch1_reg;
    logic                       eob1_reg;
    sdm_pkg::sample_t           smp1_reg [sdm_pkg::NumCh];

    logic [sdm_pkg::CountW-1:0] ch_in;
    sdm_pkg::sample_t           raw [sdm_pkg::NumCh];
    sdm_pkg::sample_t           smp1_next [sdm_pkg::NumCh];
    logic [sdm_pkg::CountW-1:0] src;

    logic                       mix_valid;
    logic [sdm_pkg::CountW-1:0] mix_ch;
    sdm_pkg::sample_t           mix_smp [sdm_pkg::NumCh];
    logic                       mix_eob;

    assign en            = !mix_valid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swz_reg <= '0;
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (sdm_pkg::cfg_idx_t'(cfg_index))
                sdm_pkg::CFG_SWIZZLE:   swz_reg                <= cfg_data[1:0];
                sdm_pkg::CFG_STEREO:    cfg_reg.stereo_only    <= cfg_data[0];
                sdm_pkg::CFG_PH_LFE:    cfg_reg.phantom_lfe    <= cfg_data[0];
                sdm_pkg::CFG_PH_CENTER: cfg_reg.phantom_center <= cfg_data[0];
                sdm_pkg::CFG_GAIN_EN:   cfg_reg.gain_enable    <= cfg_data[0];
                sdm_pkg::CFG_GAINS_LO:  cfg_reg.gains[2:0]     <= cfg_data;
                sdm_pkg::CFG_GAINS_HI:  cfg_reg.gains[5:3]     <= cfg_data;
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        ch_in = s_axis_tdata[sdm_pkg::CountW-1:0];
        if (ch_in == 3'd0)
            ch_in = 3'd1;
        else if (ch_in == 3'd7)
            ch_in = 3'd6;

        for (int c = 0; c < sdm_pkg::NumCh; c++)
        begin
            if (c < int'(ch_in))
                raw[c] = s_axis_tdata[sdm_pkg::CountW + sdm_pkg::SampleW*c +: sdm_pkg::SampleW];
            else
                raw[c] = '0;
        end

        src = '0;
        for (int c = 0; c < sdm_pkg::NumCh; c++)
        begin
            src = sdm_pkg::CountW'(c);
            if (ch_in > 3'd2)
            begin
                unique case (sdm_pkg::swz_mode_t'(swz_reg))
                    sdm_pkg::SWZ_AAC:  src = sdm_pkg::AacTab[c];
                    sdm_pkg::SWZ_AC3:  src = sdm_pkg::Ac3Tab[c];
                    sdm_pkg::SWZ_NONE,
                    sdm_pkg::SWZ_RSVD: src = sdm_pkg::CountW'(c);
                endcase
            end
            smp1_next[c] = raw[src];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ch1_reg  <= ch_in;
            eob1_reg <= s_axis_tlast;
            smp1_reg <= smp1_next;
        end
    end

    sdm_mix u_mix
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1_reg),
        .in_ch     (ch1_reg),
        .in_smp    (smp1_reg),
        .in_eob    (eob1_reg),
        .cfg       (cfg_reg),
        .out_valid (mix_valid),
        .out_ch    (mix_ch),
        .out_smp   (mix_smp),
        .out_eob   (mix_eob)
    );

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[sdm_pkg::CountW-1:0] = mix_ch;
        for (int c = 0; c < sdm_pkg::NumCh; c++)
            m_axis_tdata[sdm_pkg::CountW + sdm_pkg::SampleW*c +: sdm_pkg::SampleW] = mix_smp[c];
    end

    assign m_axis_tvalid = mix_valid;
    assign m_axis_tlast  = mix_eob;

endmodule

// ----- rtl/core/sdm_mix.sv -----
// Mixing pipeline of the surround downmix mixer: downmix, phantom fold,
// soft gain, clipping and output masking over five register stages.
// Depends on sdm_pkg.
module sdm_mix
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [sdm_pkg::CountW-1:0]  in_ch,
    input  sdm_pkg::sample_t            in_smp [sdm_pkg::NumCh],
    input  logic                        in_eob,
    input  sdm_pkg::mix_cfg_t           cfg,
    output logic                        out_valid,
    output logic [sdm_pkg::CountW-1:0]  out_ch,
    output sdm_pkg::sample_t            out_smp [sdm_pkg::NumCh],
    output logic                        out_eob
);

    // stage 2: products
    logic                       v2_reg;
    logic [sdm_pkg::CountW-1:0] ch2_reg;
    logic                       eob2_reg;
    sdm_pkg::sample_t           smp2_reg [sdm_pkg::NumCh];
    sdm_pkg::prod_t             pl_reg, pr_reg, pc_reg, plfe_reg, pbl_reg, pbr_reg;
    sdm_pkg::prod_t             zlfe2_reg, zc2_reg;

    // stage 3: downmix
    logic                       v3_reg;
    logic [sdm_pkg::CountW-1:0] ch3_reg;
    logic                       eob3_reg;
    sdm_pkg::sample_t           smp3_reg [sdm_pkg::NumCh];
    sdm_pkg::prod_t             zlfe3_reg, zc3_reg;
    logic                       ap_lfe_reg, ap_c_reg;

    // stage 4: phantom fold
    logic                       v4_reg;
    logic [sdm_pkg::CountW-1:0] ch4_reg;
    logic                       eob4_reg;
    sdm_pkg::sample_t           smp4_reg [sdm_pkg::NumCh];

    // stage 5: gain products
    logic                       v5_reg;
    logic [sdm_pkg::CountW-1:0] ch5_reg;
    logic                       eob5_reg;
    sdm_pkg::prod_t             g5_reg [sdm_pkg::NumCh];

    // stage 6: output
    logic                       v6_reg;
    logic [sdm_pkg::CountW-1:0] ch6_reg;
    logic                       eob6_reg;
    sdm_pkg::sample_t           smp6_reg [sdm_pkg::NumCh];

    logic                         dmx;
    logic [sdm_pkg::CountW-1:0]   ch3_next;
    logic signed [sdm_pkg::SumW-1:0] sum_l, sum_r;
    sdm_pkg::sample_t             l3_next, r3_next;
    sdm_pkg::sample_t             l_lfe, r_lfe, l4_next, r4_next;
    sdm_pkg::sample_t             smp3_next [sdm_pkg::NumCh];
    sdm_pkg::sample_t             smp4_next [sdm_pkg::NumCh];

    always_comb
    begin
        dmx      = cfg.stereo_only && (ch2_reg == 3'd6);
        ch3_next = dmx ? 3'd2 : ch2_reg;
        sum_l = sdm_pkg::SumW'(pl_reg) + sdm_pkg::SumW'(pc_reg) + sdm_pkg::SumW'(plfe_reg)
              - sdm_pkg::SumW'(pbl_reg) - sdm_pkg::SumW'(pbr_reg);
        sum_r = sdm_pkg::SumW'(pr_reg) + sdm_pkg::SumW'(pc_reg) + sdm_pkg::SumW'(plfe_reg)
              + sdm_pkg::SumW'(pbl_reg) + sdm_pkg::SumW'(pbr_reg);
        l3_next = dmx ? sdm_pkg::clip16(sum_l) : smp2_reg[0];
        r3_next = dmx ? sdm_pkg::clip16(sum_r) : smp2_reg[1];
        smp3_next    = smp2_reg;
        smp3_next[0] = l3_next;
        smp3_next[1] = r3_next;
    end

    always_comb
    begin
        l_lfe = smp3_reg[0];
        r_lfe = smp3_reg[1];
        if (ap_lfe_reg)
        begin
            l_lfe = sdm_pkg::clip16(sdm_pkg::SumW'(smp3_reg[0]) + sdm_pkg::SumW'(zlfe3_reg));
            r_lfe = sdm_pkg::clip16(sdm_pkg::SumW'(smp3_reg[1]) + sdm_pkg::SumW'(zlfe3_reg));
        end
        l4_next = l_lfe;
        r4_next = r_lfe;
        if (ap_c_reg)
        begin
            l4_next = sdm_pkg::clip16(sdm_pkg::SumW'(l_lfe) + sdm_pkg::SumW'(zc3_reg));
            r4_next = sdm_pkg::clip16(sdm_pkg::SumW'(r_lfe) + sdm_pkg::SumW'(zc3_reg));
        end
        smp4_next    = smp3_reg;
        smp4_next[0] = l4_next;
        smp4_next[1] = r4_next;
        if (ap_c_reg)
            smp4_next[4] = '0;
        if (ap_lfe_reg)
            smp4_next[5] = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= in_valid;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ch2_reg   <= in_ch;
            eob2_reg  <= in_eob;
            smp2_reg  <= in_smp;
            pl_reg    <= sdm_pkg::fmul(in_smp[0], sdm_pkg::CoefFront);
            pr_reg    <= sdm_pkg::fmul(in_smp[1], sdm_pkg::CoefFront);
            pbl_reg   <= sdm_pkg::fmul(in_smp[2], sdm_pkg::CoefLfe);
            pbr_reg   <= sdm_pkg::fmul(in_smp[3], sdm_pkg::CoefCenter);
            pc_reg    <= sdm_pkg::fmul(in_smp[4], sdm_pkg::CoefCenter);
            plfe_reg  <= sdm_pkg::fmul(in_smp[5], sdm_pkg::CoefLfe);
            zc2_reg   <= sdm_pkg::fmul(in_smp[4], sdm_pkg::CoefPhantom);
            zlfe2_reg <= sdm_pkg::fmul(in_smp[5], sdm_pkg::CoefPhantom);

            ch3_reg     <= ch3_next;
            eob3_reg    <= eob2_reg;
            smp3_reg    <= smp3_next;
            zlfe3_reg   <= zlfe2_reg;
            zc3_reg     <= zc2_reg;
            ap_lfe_reg  <= cfg.phantom_lfe && (ch3_next > 3'd5);
            ap_c_reg    <= cfg.phantom_center && (ch3_next > 3'd4);

            ch4_reg     <= ch3_reg;
            eob4_reg    <= eob3_reg;
            smp4_reg    <= smp4_next;

            ch5_reg  <= ch4_reg;
            eob5_reg <= eob4_reg;
            for (int c = 0; c < sdm_pkg::NumCh; c++)
            begin
                if (cfg.gain_enable)
                    g5_reg[c] <= sdm_pkg::fmul(smp4_reg[c], cfg.gains[c]);
                else
                    g5_reg[c] <= sdm_pkg::ProdW'(smp4_reg[c]);
            end

            ch6_reg  <= ch5_reg;
            eob6_reg <= eob5_reg;
            for (int c = 0; c < sdm_pkg::NumCh; c++)
            begin
                if (c < int'(ch5_reg))
                    smp6_reg[c] <= sdm_pkg::clip16(sdm_pkg::SumW'(g5_reg[c]));
                else
                    smp6_reg[c] <= '0;
            end
        end
    end

    assign out_valid = v6_reg;
    assign out_ch    = ch6_reg;
    assign out_smp   = smp6_reg;
    assign out_eob   = eob6_reg;

endmodule

// ----- verif/downmix_check_pkg.sv -----
// Frame type, expected-frame predictor and scoreboard for the surround downmix mixer bench.
// Depends on sdm_pkg for widths and the register/mode codes.
package downmix_check_pkg;

    import sdm_pkg::*;

    typedef struct packed {
        logic                          eob;
        logic [NumCh-1:0][SampleW-1:0] smp;
        logic [CountW-1:0]             count;
    } frame_t;

    localparam longint K_FRONT   = 26869;
    localparam longint K_CENTER  = 19196;
    localparam longint K_LFE     = 13571;
    localparam longint K_PHANTOM = 46334;

    // floor(v * k / 2^16)
    function automatic longint scale_q16(longint v, longint k);
        return (v * k) >>> 16;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    class downmix_scoreboard;
        frame_t                        expected_frames[$];
        int unsigned                   mismatches;
        int unsigned                   results_seen;
        swz_mode_t                     swizzle;
        logic                          stereo_only;
        logic                          phantom_lfe;
        logic                          phantom_center;
        logic                          gain_on;
        logic [NumCh-1:0][SampleW-1:0] gain_q16;

        function new();
            mismatches     = 0;
            results_seen   = 0;
            swizzle        = SWZ_NONE;
            stereo_only    = 1'b0;
            phantom_lfe    = 1'b0;
            phantom_center = 1'b0;
            gain_on        = 1'b0;
            gain_q16       = '0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [CfgW-1:0] value);
            case (idx)
                CFG_SWIZZLE:   swizzle = swz_mode_t'(value[1:0]);
                CFG_STEREO:    stereo_only = value[0];
                CFG_PH_LFE:    phantom_lfe = value[0];
                CFG_PH_CENTER: phantom_center = value[0];
                CFG_GAIN_EN:   gain_on = value[0];
                CFG_GAINS_LO:  for (int k = 0; k < 3; k++) gain_q16[k] = value[16*k +: 16];
                CFG_GAINS_HI:  for (int k = 0; k < 3; k++) gain_q16[k+3] = value[16*k +: 16];
                default:       ;
            endcase
        endfunction

        function frame_t mix_frame(frame_t f);
            longint raw[NumCh];
            longint mixed[NumCh];
            longint x;
            longint y;
            longint z;
            int     n;
            int     src;
            frame_t r;
            n = int'(f.count);
            if (n < 1)
                n = 1;
            if (n > NumCh)
                n = NumCh;
            for (int c = 0; c < NumCh; c++)
                raw[c] = (c < n) ? longint'($signed(f.smp[c])) : 0;
            for (int c = 0; c < NumCh; c++)
            begin
                src = c;
                if (n > 2 && c < n)
                begin
                    if (swizzle == SWZ_AAC)
                    begin
                        case (c)
                            0: src = 1;
                            1: src = 2;
                            2: src = 4;
                            3: src = 5;
                            4: src = 0;
                            default: src = 3;
                        endcase
                    end
                    else if (swizzle == SWZ_AC3)
                    begin
                        case (c)
                            0: src = 0;
                            1: src = 2;
                            2: src = 3;
                            3: src = 4;
                            4: src = 1;
                            default: src = 5;
                        endcase
                    end
                end
                mixed[c] = raw[src];
            end
            if (n == NumCh && stereo_only)
            begin
                x = scale_q16(mixed[0], K_FRONT);
                y = scale_q16(mixed[1], K_FRONT);
                z = scale_q16(mixed[4], K_CENTER);
                x += z;
                y += z;
                z = scale_q16(mixed[5], K_LFE);
                x += z;
                y += z;
                z = scale_q16(mixed[2], K_LFE);
                x -= z;
                y += z;
                z = scale_q16(mixed[3], K_CENTER);
                x -= z;
                y += z;
                mixed[0] = clamp16(x);
                mixed[1] = clamp16(y);
                n = 2;
            end
            if (phantom_lfe && n > 5)
            begin
                z = scale_q16(mixed[5], K_PHANTOM);
                mixed[0] = clamp16(mixed[0] + z);
                mixed[1] = clamp16(mixed[1] + z);
                mixed[5] = 0;
            end
            if (phantom_center && n > 4)
            begin
                z = scale_q16(mixed[4], K_PHANTOM);
                mixed[0] = clamp16(mixed[0] + z);
                mixed[1] = clamp16(mixed[1] + z);
                mixed[4] = 0;
            end
            if (gain_on)
            begin
                for (int c = 0; c < n; c++)
                    mixed[c] = clamp16(scale_q16(mixed[c], longint'(gain_q16[c])));
            end
            r.count = n[CountW-1:0];
            for (int c = 0; c < NumCh; c++)
                r.smp[c] = (c < n) ? mixed[c][SampleW-1:0] : '0;
            r.eob = f.eob;
            return r;
        endfunction

        function void note_frame_in(frame_t f);
            expected_frames.push_back(mix_frame(f));
        endfunction

        task report(string msg);
            if (mismatches < 100)
                $display("[%0t] MISMATCH %s", $realtime, msg);
            mismatches++;
        endtask

        task check_frame_out(frame_t got);
            frame_t want;
            if (expected_frames.size() == 0)
            begin
                report($sformatf("unexpected output beat %0h", got));
                results_seen++;
                return;
            end
            want = expected_frames.pop_front();
            if (got.count !== want.count)
                report($sformatf("beat %0d count: got %0d want %0d",
                                 results_seen, got.count, want.count));
            for (int c = 0; c < NumCh; c++)
            begin
                if (got.smp[c] !== want.smp[c])
                    report($sformatf("beat %0d sample %0d: got %0h want %0h",
                                     results_seen, c, got.smp[c], want.smp[c]));
            end
            if (got.eob !== want.eob)
                report($sformatf("beat %0d tlast: got %0b want %0b",
                                 results_seen, got.eob, want.eob));
            results_seen++;
        endtask
    endclass

endpackage

// ----- verif/tb_surround_downmix_mixer.sv -----
// Top-level bench for surround_downmix_mixer: drives frames and register writes,
// stalls both stream sides at random and checks every output beat in order.
// Depends on sdm_pkg, downmix_check_pkg and the RTL.
module tb_surround_downmix_mixer;

    timeunit 1ns;
    timeprecision 1ps;

    import sdm_pkg::*;
    import downmix_check_pkg::*;

    localparam int NUM_PHASES     = 8;
    localparam int DIRECTED_PH    = 4;
    localparam int FRAMES_PER_PH  = 85;
    localparam int PRESSURE_AT    = 150;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 20;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    // channel_count[2:0], in_sample_0..5 at [18:3] .. [98:83], zero pad
    logic [DataW-1:0]    s_axis_tdata;
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // out_channel_count[2:0], out_sample_0..5 at [18:3] .. [98:83], zero pad
    logic [DataW-1:0]    m_axis_tdata;
    logic                m_axis_tlast;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgW-1:0]     cfg_data;

    downmix_scoreboard   sb;
    int unsigned         frames_sent = 0;
    bit                  gapless = 1'b0;

    surround_downmix_mixer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap(bit no_idle);
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 0;
        if (r < 9)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SampleW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return SampleW'($urandom());
        endcase
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        if ($urandom_range(0, 1))
            f.count = 3'd6;
        else
            f.count = CountW'($urandom_range(0, 7));
        for (int c = 0; c < NumCh; c++)
            f.smp[c] = pick_sample();
        f.eob = 1'($urandom_range(0, 1));
        return f;
    endfunction

    function automatic frame_t extreme_frame(int cnt, int pattern, bit eob);
        frame_t f;
        f.count = cnt[CountW-1:0];
        f.eob   = eob;
        for (int c = 0; c < NumCh; c++)
        begin
            case (pattern)
                0:       f.smp[c] = 16'h7FFF;
                1:       f.smp[c] = 16'h8000;
                2:       f.smp[c] = (c % 2) ? 16'h8000 : 16'h7FFF;
                default: f.smp[c] = (c % 2) ? 16'h7FFF : 16'h8000;
            endcase
        end
        return f;
    endfunction

    function automatic logic [CfgW-1:0] random_gains();
        logic [CfgW-1:0] g;
        for (int k = 0; k < 3; k++)
        begin
            case ($urandom_range(0, 3))
                0:       g[16*k +: 16] = 16'hFFFF;
                1:       g[16*k +: 16] = 16'($urandom_range(0, 16'h1000));
                default: g[16*k +: 16] = 16'($urandom());
            endcase
        end
        return g;
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [CfgW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic configure_phase(int phase);
        swz_mode_t       swz;
        logic [3:0]      flags;
        logic [CfgW-1:0] g_lo;
        logic [CfgW-1:0] g_hi;
        case (phase)
            0:
            begin
                swz   = SWZ_NONE;
                flags = 4'b0000;
                g_lo  = '0;
                g_hi  = '0;
            end
            1:
            begin
                swz   = SWZ_AAC;
                flags = 4'b1111;
                g_lo  = '1;
                g_hi  = '1;
            end
            2:
            begin
                swz   = SWZ_AC3;
                flags = 4'b1110;
                g_lo  = '0;
                g_hi  = '0;
            end
            3:
            begin
                swz   = SWZ_RSVD;
                flags = 4'b1001;
                g_lo  = random_gains();
                g_hi  = random_gains();
            end
            default:
            begin
                swz   = swz_mode_t'($urandom_range(0, 3));
                flags = 4'($urandom_range(0, 15));
                g_lo  = random_gains();
                g_hi  = random_gains();
            end
        endcase
        // flags: stereo_only, phantom_lfe, phantom_center, gain_enable (msb first)
        write_reg(CFG_SWIZZLE, CfgW'(swz));
        write_reg(CFG_STEREO, CfgW'(flags[3]));
        write_reg(CFG_PH_LFE, CfgW'(flags[2]));
        write_reg(CFG_PH_CENTER, CfgW'(flags[1]));
        write_reg(CFG_GAIN_EN, CfgW'(flags[0]));
        write_reg(CFG_GAINS_LO, g_lo);
        write_reg(CFG_GAINS_HI, g_hi);
        cfg_we <= 1'b0;
    endtask

    task automatic send_frame(frame_t f);
        int gap;
        gap = pick_gap(gapless);
        repeat (gap)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DataW'({f.smp, f.count});
        s_axis_tlast  <= f.eob;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_frame_in(f);
        frames_sent++;
    endtask

    task automatic wait_drained();
        while (sb.expected_frames.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int dir_counts[6];
        sb            = new();
        dir_counts    = '{0, 7, 6, 6, 5, 3};
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_SWIZZLE;
        cfg_data      = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            configure_phase(phase);
            gapless = (phase % 3 == 2);
            if (phase < DIRECTED_PH)
            begin
                for (int k = 0; k < 6; k++)
                    send_frame(extreme_frame(dir_counts[k], (k + phase) % 4, k[0]));
            end
            for (int i = 0; i < FRAMES_PER_PH; i++)
                send_frame(random_frame());
            s_axis_tvalid <= 1'b0;
            wait_drained();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_frames.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // output side: random backpressure plus one long hold-off to fill the pipe
    initial
    begin
        int run_left;
        bit pressure_done;
        frame_t got;
        m_axis_tready = 1'b0;
        run_left      = 0;
        pressure_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.count = m_axis_tdata[CountW-1:0];
                got.smp   = m_axis_tdata[CountW +: NumCh*SampleW];
                got.eob   = m_axis_tlast;
                sb.check_frame_out(got);
            end
            if (!pressure_done && frames_sent >= PRESSURE_AT)
            begin
                pressure_done = 1'b1;
                m_axis_tready <= 1'b0;
                run_left      = LONG_HOLD;
            end
            else if (run_left > 0)
                run_left--;
            else if ($urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                run_left      = pick_gap(1'b0);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                run_left      = $urandom_range(0, 40);
            end
        end
    end

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/sdm_pkg.sv
rtl/core/sdm_mix.sv
rtl/core/surround_downmix_mixer.sv
verif/downmix_check_pkg.sv
verif/tb_surround_downmix_mixer.sv
